// ===== design/gillespie_ssa_step_engine_top_macros.svh =====
`ifndef GILLESPIE_SSA_STEP_ENGINE_TOP_MACROS_SVH
`define GILLESPIE_SSA_STEP_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define GSSA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GSSA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/gssa_pkg.sv =====
package gssa_pkg;

   localparam int RATE_W     = 36;
   localparam int TIME_W     = 48;
   localparam int INIT_N_W   = 26;
   localparam int REACTIONS  = 10;
   localparam int RXN_W      = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 48;
   localparam int STOP_W     = 3;

   localparam logic [46:0]       HILL_K2  = 47'd100000000000000;
   localparam logic [31:0]       LN2_Q32  = 32'd2977044472;
   localparam logic [19:0]       START_S  = 20'd550000;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   localparam logic KIND_START = 1'b0;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_END     = 3'd1,
      STAT_ZERO    = 3'd2,
      STAT_NO_RUN  = 3'd3,
      STAT_EXTINCT = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GROWTH_N   = 4'd0,
      CSR_GROWTH_G1  = 4'd1,
      CSR_DEATH_S    = 4'd2,
      CSR_DEATH_N    = 4'd3,
      CSR_INITIAL_N  = 4'd4,
      CSR_TIME_END   = 4'd5,
      CSR_STOP_MODE  = 4'd6,
      CSR_FRAC_BASE  = 4'd7
   } csr_index_type;

   localparam logic [STOP_W-1:0] STOP_APPEAR    = 3'd1;
   localparam logic [STOP_W-1:0] STOP_ESTABLISH = 3'd2;
   localparam logic [STOP_W-1:0] STOP_NEVER     = 3'd4;

   // reaction numbering
   localparam logic [RXN_W-1:0] RXN_GROW_S  = 4'd0;
   localparam logic [RXN_W-1:0] RXN_GROW_N  = 4'd1;
   localparam logic [RXN_W-1:0] RXN_GROW_G  = 4'd2;
   localparam logic [RXN_W-1:0] RXN_S_TO_N  = 4'd3;
   localparam logic [RXN_W-1:0] RXN_N_TO_S  = 4'd4;
   localparam logic [RXN_W-1:0] RXN_S_TO_G  = 4'd5;
   localparam logic [RXN_W-1:0] RXN_N_TO_G  = 4'd6;
   localparam logic [RXN_W-1:0] RXN_DIE_S   = 4'd7;
   localparam logic [RXN_W-1:0] RXN_DIE_N   = 4'd8;
   localparam logic [RXN_W-1:0] RXN_DIE_G   = 4'd9;

   typedef enum logic [1:0] {
      EFF_NONE = 2'd0,
      EFF_INC  = 2'd1,
      EFF_DEC  = 2'd2
   } eff_type;

   typedef struct packed {
      eff_type s;
      eff_type n;
      eff_type g;
   } eff_set_type;

   function automatic eff_set_type reaction_effect(input logic [RXN_W-1:0] idx);
      eff_set_type e;
      e = '{s: EFF_NONE, n: EFF_NONE, g: EFF_NONE};
      case (idx)
         RXN_GROW_S: e.s = EFF_INC;
         RXN_GROW_N: e.n = EFF_INC;
         RXN_GROW_G: e.g = EFF_INC;
         RXN_S_TO_N: begin
            e.s = EFF_DEC;
            e.n = EFF_INC;
         end
         RXN_N_TO_S: begin
            e.s = EFF_INC;
            e.n = EFF_DEC;
         end
         RXN_S_TO_G: begin
            e.s = EFF_DEC;
            e.g = EFF_INC;
         end
         RXN_N_TO_G: begin
            e.n = EFF_DEC;
            e.g = EFF_INC;
         end
         RXN_DIE_S: e.s = EFF_DEC;
         RXN_DIE_N: e.n = EFF_DEC;
         RXN_DIE_G: e.g = EFF_DEC;
         default: e = '{s: EFF_NONE, n: EFF_NONE, g: EFF_NONE};
      endcase
      return e;
   endfunction

   // drug is off in the second half of each 24 h window, hours 12..239
   function automatic logic hour_drug_off(input logic [7:0] hr);
      logic off;
      off = 1'b0;
      for (int k = 0; k < 10; k++) begin
         if (hr >= 8'(24 * k + 12) && hr < 8'(24 * k + 24)) off = 1'b1;
      end
      return off;
   endfunction

endpackage

// ===== design/gssa_divider.sv =====
module gssa_divider #(
   parameter int W = 80
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] numer,
   input  logic [W-1:0] denom,
   output logic [W-1:0] quot,
   output logic         done
);

   localparam int CNT_W = $clog2(W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W:0]       rem_ff, rem_in;
   logic [W-1:0]     q_ff, q_in;
   logic [W-1:0]     den_ff, den_in;
   logic [W:0]       shifted;
   logic             fits;

   assign shifted = {rem_ff[W-1:0], q_ff[W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(W - 1);
         rem_in  = '0;
         q_in    = numer;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = fits ? shifted - {1'b0, den_ff} : shifted;
         q_in   = {q_ff[W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign quot = q_ff;
   assign done = done_ff;

endmodule

// ===== design/gillespie_ssa_step_engine_top.sv =====
// Gillespie direct-method event engine: one request in, one response out. A start request
// (tuser 0) loads a new trajectory and answers without running an event; a step request (tuser 1)
// runs one reaction event. The event time is set by two passes of the shared bit-serial
// divider (Hill factor, then the waiting time, DIV_W bits wide, 80 by default), the 32
// square-and-normalize steps of the log2 unit on the shared multiplier, ten propensity
// products and a scan of the cumulative sum. Requests are taken only while the engine is
// idle; a finished response sits in the output register, so the next request is taken
// while it waits.
`include "gillespie_ssa_step_engine_top_macros.svh"

module gillespie_ssa_step_engine_top
   import gssa_pkg::*;
#(
   parameter int COUNT_BITS     = 26,
   parameter int TIME_FRAC_BITS = 32,
   parameter int RATE_FRAC_BITS = 32,
   localparam int DATA_W = ((4 * TIME_W + 3 * COUNT_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // tdata: rand_one [31:0], rand_two [63:32]
   input  logic [63:0]           req_tdata,
   // tuser: kind [0]
   input  logic [0:0]            req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: time_now, count_s, count_n, count_g1, appear_time, establish_time,
   // fixation_time, zero fill
   output logic [DATA_W-1:0]     rsp_tdata,
   // tuser: status [2:0], appear_found [3], establish_found [4], fixation_found [5]
   output logic [5:0]            rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CB     = COUNT_BITS;
   localparam int TOT_W  = CB + 2;
   localparam int PW     = RATE_W + CB;
   localparam int AW     = PW + 4;
   localparam int TGT_W  = AW + 32;
   localparam int MW     = CB + 7;
   localparam int LN_W   = 37;
   localparam int NUM_SH = TIME_FRAC_BITS + RATE_FRAC_BITS - 32;
   localparam int NW     = LN_W + NUM_SH;
   localparam int DIV_W  = (NW > 80) ? NW : 80;

   localparam logic [CB-1:0] COUNT_MAX = '1;

   localparam logic [63:0] RQ_GS = ((64'd3466 << RATE_FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic [63:0] RQ_GN = ((64'd2600 << RATE_FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic [63:0] RQ_GG = ((64'd1733 << RATE_FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic [63:0] RQ_NS = ((64'd625 << RATE_FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic [63:0] RQ_SN = ((64'd35 << RATE_FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic [63:0] RQ_G1 = ((64'd1 << RATE_FRAC_BITS) + 64'd1500000) / 64'd3000000;
   localparam logic [63:0] RQ_D  = ((64'd1 << RATE_FRAC_BITS) + 64'd78) / 64'd156;
   localparam logic [RATE_W-1:0] K_GS = RQ_GS[RATE_W-1:0];
   localparam logic [RATE_W-1:0] K_GN = RQ_GN[RATE_W-1:0];
   localparam logic [RATE_W-1:0] K_GG = RQ_GG[RATE_W-1:0];
   localparam logic [RATE_W-1:0] K_NS = RQ_NS[RATE_W-1:0];
   localparam logic [RATE_W-1:0] K_SN = RQ_SN[RATE_W-1:0];
   localparam logic [RATE_W-1:0] K_G1 = RQ_G1[RATE_W-1:0];
   localparam logic [RATE_W-1:0] K_D  = RQ_D[RATE_W-1:0];

   localparam logic [TIME_W-1:0] T12  = 48'd12 << TIME_FRAC_BITS;
   localparam logic [TIME_W-1:0] T240 = 48'd240 << TIME_FRAC_BITS;
   localparam logic [DIV_W-1:0]  HILL_NUM = DIV_W'(HILL_K2) << 32;

   typedef enum logic [20:0] {
      ST_IDLE  = 21'h000001,
      ST_SQ    = 21'h000002,
      ST_HGO   = 21'h000004,
      ST_HWAIT = 21'h000008,
      ST_PDAMP = 21'h000010,
      ST_PMUL  = 21'h000020,
      ST_PACC  = 21'h000040,
      ST_CHK   = 21'h000080,
      ST_LMUL  = 21'h000100,
      ST_LNRM  = 21'h000200,
      ST_LNLO  = 21'h000400,
      ST_LNHI  = 21'h000800,
      ST_LNADD = 21'h001000,
      ST_TWAIT = 21'h002000,
      ST_TGLO  = 21'h004000,
      ST_TGHI  = 21'h008000,
      ST_TGADD = 21'h010000,
      ST_SEL   = 21'h020000,
      ST_UPD   = 21'h040000,
      ST_MARK  = 21'h080000,
      ST_OUT   = 21'h100000
   } state_type;

   // configuration
   logic [RATE_W-1:0]   cfg_gn_ff, cfg_gn_in, cfg_gg_ff, cfg_gg_in;
   logic [RATE_W-1:0]   cfg_ds_ff, cfg_ds_in, cfg_dn_ff, cfg_dn_in;
   logic [INIT_N_W-1:0] cfg_init_n_ff, cfg_init_n_in;
   logic [TIME_W-1:0]   cfg_tend_ff, cfg_tend_in;
   logic [STOP_W-1:0]   cfg_stop_ff, cfg_stop_in;
   logic                cfg_fbase_ff, cfg_fbase_in;

   // trajectory state
   state_type           state_ff, state_in;
   logic                run_ff, run_in;
   logic [CB-1:0]       s_ff, s_in, n_ff, n_in, g_ff, g_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [CB:0]         start_tot_ff, start_tot_in;
   logic [TIME_W-1:0]   app_t_ff, app_t_in, est_t_ff, est_t_in, fix_t_ff, fix_t_in;
   logic                app_ff, app_in, est_ff, est_in, fix_ff, fix_in;
   status_type          stat_ff, stat_in;

   // event datapath
   logic [31:0]         r1_ff, r1_in, r2_ff, r2_in;
   logic                off_ff, off_in;
   logic [32:0]         hill_ff, hill_in;
   logic [RXN_W-1:0]    idx_ff, idx_in;
   logic [AW-1:0]       a0_ff, a0_in;
   logic [PW-1:0]       prop_ff [REACTIONS];
   logic [PW-1:0]       prop_in [REACTIONS];
   logic [31:0]         m_ff, m_in;
   logic [4:0]          e_ff, e_in;
   logic [31:0]         frac_ff, frac_in;
   logic [4:0]          lcnt_ff, lcnt_in;
   logic [107:0]        acc_ff, acc_in;
   logic [TGT_W-1:0]    target_ff, target_in;
   logic [AW-1:0]       cum_ff, cum_in;
   logic                found_ff, found_in;
   logic [RXN_W-1:0]    pick_ff, pick_in;

   // shared multiplier
   logic [RATE_W-1:0]   mul_a, mul_b;
   logic [71:0]         prod_ff;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [5:0]          rsp_user_ff, rsp_user_in;

   // divider
   logic                div_start, div_done;
   logic [DIV_W-1:0]    div_num, div_den, div_quot;

   // helpers
   logic [TOT_W-1:0]    total;
   logic [TIME_W-1:0]   tm1;
   logic                drug_off;
   logic [RATE_W-1:0]   rate_cur;
   logic [CB-1:0]       count_cur;
   logic [4:0]          lead;
   logic [37:0]         l2;
   logic [107:0]        wsum;
   logic [32:0]         sq_norm;
   logic [TIME_W:0]     time_sum;
   logic [TIME_W-1:0]   tau;
   logic [AW-1:0]       cum_next;
   eff_set_type         eff;
   logic [TOT_W-1:0]    cur_tot, base;
   logic [MW-1:0]       g20, b19;
   logic                stop;

   function automatic logic [CB-1:0] bump(input logic [CB-1:0] c, input eff_type d);
      logic [CB-1:0] r;
      r = c;
      case (d)
         EFF_INC:  r = (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
         EFF_DEC:  r = (c == '0) ? '0 : c - 1'b1;
         default:  r = c;
      endcase
      return r;
   endfunction

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_gn_in     = cfg_gn_ff;
      cfg_gg_in     = cfg_gg_ff;
      cfg_ds_in     = cfg_ds_ff;
      cfg_dn_in     = cfg_dn_ff;
      cfg_init_n_in = cfg_init_n_ff;
      cfg_tend_in   = cfg_tend_ff;
      cfg_stop_in   = cfg_stop_ff;
      cfg_fbase_in  = cfg_fbase_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GROWTH_N:  cfg_gn_in     = csr_data[RATE_W-1:0];
            CSR_GROWTH_G1: cfg_gg_in     = csr_data[RATE_W-1:0];
            CSR_DEATH_S:   cfg_ds_in     = csr_data[RATE_W-1:0];
            CSR_DEATH_N:   cfg_dn_in     = csr_data[RATE_W-1:0];
            CSR_INITIAL_N: cfg_init_n_in = csr_data[INIT_N_W-1:0];
            CSR_TIME_END:  cfg_tend_in   = csr_data[TIME_W-1:0];
            CSR_STOP_MODE: cfg_stop_in   = csr_data[STOP_W-1:0];
            CSR_FRAC_BASE: cfg_fbase_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------- combinational helpers ----------------
   assign total    = TOT_W'(s_ff) + TOT_W'(n_ff) + TOT_W'(g_ff);
   assign tm1      = time_ff - 48'd1;
   assign drug_off = (time_ff > T12) && (time_ff <= T240)
                     && hour_drug_off(tm1[TIME_FRAC_BITS +: 8]);

   always_comb begin
      rate_cur = '0;
      case (idx_ff)
         RXN_GROW_S: rate_cur = off_ff ? K_GS : '0;
         RXN_GROW_N: rate_cur = off_ff ? K_GN : cfg_gn_ff;
         RXN_GROW_G: rate_cur = off_ff ? K_GG : cfg_gg_ff;
         RXN_S_TO_N: rate_cur = K_NS;
         RXN_N_TO_S: rate_cur = K_SN;
         RXN_S_TO_G: rate_cur = off_ff ? K_G1 : '0;
         RXN_N_TO_G: rate_cur = K_G1;
         RXN_DIE_S:  rate_cur = off_ff ? K_D : cfg_ds_ff;
         RXN_DIE_N:  rate_cur = off_ff ? K_D : cfg_dn_ff;
         RXN_DIE_G:  rate_cur = K_D;
         default:    rate_cur = '0;
      endcase
   end

   always_comb begin
      if (idx_ff inside {RXN_GROW_S, RXN_S_TO_N, RXN_S_TO_G, RXN_DIE_S}) count_cur = s_ff;
      else if (idx_ff inside {RXN_GROW_N, RXN_N_TO_S, RXN_N_TO_G, RXN_DIE_N}) count_cur = n_ff;
      else count_cur = g_ff;
   end

   always_comb begin
      lead = '0;
      for (int i = 0; i < 32; i++) begin
         if (r1_ff[i]) lead = 5'(i);
      end
   end

   assign l2       = (38'd32 << 32) - {1'b0, e_ff, frac_ff};
   assign wsum     = acc_ff + {prod_ff, 36'b0};
   assign sq_norm  = prod_ff[63:31];
   assign time_sum = {1'b0, time_ff} + {1'b0, tau};
   assign tau      = (div_quot[DIV_W-1:TIME_W] != '0) ? TIME_MAX : div_quot[TIME_W-1:0];
   assign cum_next = cum_ff + AW'(prop_ff[idx_ff]);
   assign eff      = reaction_effect(pick_ff);
   assign cur_tot  = TOT_W'(s_ff) + TOT_W'(n_ff) + TOT_W'(g_ff);
   assign base     = cfg_fbase_ff ? cur_tot : TOT_W'(start_tot_ff);
   assign g20      = (MW'(g_ff) << 4) + (MW'(g_ff) << 2);
   assign b19      = (MW'(base) << 4) + (MW'(base) << 1) + MW'(base);

   // ---------------- shared multiplier ----------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ: begin
            mul_a = RATE_W'(total);
            mul_b = RATE_W'(total);
         end
         ST_PDAMP: begin
            mul_a = rate_cur;
            mul_b = RATE_W'(hill_ff);
         end
         ST_PMUL: begin
            // Hill-damped growth rates come straight from the previous product
            mul_a = (idx_ff < RXN_S_TO_N) ? prod_ff[67:32] : rate_cur;
            mul_b = RATE_W'(count_cur);
         end
         ST_LMUL: begin
            mul_a = RATE_W'(m_ff);
            mul_b = RATE_W'(m_ff);
         end
         ST_LNLO: begin
            mul_a = l2[35:0];
            mul_b = RATE_W'(LN2_Q32);
         end
         ST_LNHI: begin
            mul_a = RATE_W'(l2[37:36]);
            mul_b = RATE_W'(LN2_Q32);
         end
         ST_TGLO: begin
            mul_a = RATE_W'(a0_ff);
            mul_b = RATE_W'(r2_ff);
         end
         ST_TGHI: begin
            mul_a = RATE_W'(72'(a0_ff) >> 36);
            mul_b = RATE_W'(r2_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // ---------------- divider ----------------
   assign div_start = (state_ff == ST_HGO) || (state_ff == ST_LNADD);
   assign div_num   = (state_ff == ST_HGO) ? HILL_NUM : DIV_W'(wsum[68:32]) << NUM_SH;
   assign div_den   = (state_ff == ST_HGO) ? DIV_W'(HILL_K2) + DIV_W'(prod_ff) : DIV_W'(a0_ff);

   gssa_divider #(.W(DIV_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .quot  (div_quot),
      .done  (div_done)
   );

   // ---------------- sequencer ----------------
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      run_in       = run_ff;
      s_in         = s_ff;
      n_in         = n_ff;
      g_in         = g_ff;
      time_in      = time_ff;
      start_tot_in = start_tot_ff;
      app_t_in     = app_t_ff;
      est_t_in     = est_t_ff;
      fix_t_in     = fix_t_ff;
      app_in       = app_ff;
      est_in       = est_ff;
      fix_in       = fix_ff;
      stat_in      = stat_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      off_in       = off_ff;
      hill_in      = hill_ff;
      idx_in       = idx_ff;
      a0_in        = a0_ff;
      prop_in      = prop_ff;
      m_in         = m_ff;
      e_in         = e_ff;
      frac_in      = frac_ff;
      lcnt_in      = lcnt_ff;
      acc_in       = acc_ff;
      target_in    = target_ff;
      cum_in       = cum_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      stop         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               r1_in  = req_tdata[31:0];
               r2_in  = req_tdata[63:32];
               off_in = drug_off;
               state_in = ST_OUT;
               if (req_tuser[0] == KIND_START) begin
                  s_in = CB'(START_S);
                  n_in = ({1'b0, 32'(cfg_init_n_ff)} > {1'b0, 32'(COUNT_MAX)})
                         ? COUNT_MAX : CB'(cfg_init_n_ff);
                  g_in = '0;
                  start_tot_in = (CB + 1)'(CB'(START_S)) + (CB + 1)'(n_in);
                  time_in  = '0;
                  app_in   = 1'b0;
                  est_in   = 1'b0;
                  fix_in   = 1'b0;
                  app_t_in = '0;
                  est_t_in = '0;
                  fix_t_in = '0;
                  run_in   = 1'b1;
                  stat_in  = STAT_OK;
               end else if (!run_ff) begin
                  stat_in = STAT_NO_RUN;
               end else if (time_ff >= cfg_tend_ff) begin
                  run_in  = 1'b0;
                  stat_in = STAT_END;
               end else begin
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ:  state_in = ST_HGO;
         ST_HGO: state_in = ST_HWAIT;
         ST_HWAIT: begin
            if (div_done) begin
               hill_in  = div_quot[32:0];
               idx_in   = '0;
               a0_in    = '0;
               state_in = ST_PDAMP;
            end
         end
         ST_PDAMP: state_in = ST_PMUL;
         ST_PMUL:  state_in = ST_PACC;
         ST_PACC: begin
            prop_in[idx_ff] = prod_ff[PW-1:0];
            a0_in = a0_ff + AW'(prod_ff[PW-1:0]);
            if (idx_ff == RXN_DIE_G) begin
               state_in = ST_CHK;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_ff < RXN_GROW_G) ? ST_PDAMP : ST_PMUL;
            end
         end
         ST_CHK: begin
            if (a0_ff == '0) begin
               run_in   = 1'b0;
               stat_in  = STAT_EXTINCT;
               state_in = ST_OUT;
            end else if (r1_ff == '0) begin
               stat_in  = STAT_ZERO;
               state_in = ST_OUT;
            end else begin
               e_in     = lead;
               m_in     = r1_ff << (5'd31 - lead);
               frac_in  = '0;
               lcnt_in  = '0;
               state_in = ST_LMUL;
            end
         end
         ST_LMUL: state_in = ST_LNRM;
         ST_LNRM: begin
            // square, keep the mantissa in [1,2); the overflow bit is the next log2 bit
            m_in    = sq_norm[32] ? sq_norm[32:1] : sq_norm[31:0];
            frac_in = {frac_ff[30:0], sq_norm[32]};
            lcnt_in = lcnt_ff + 1'b1;
            state_in = (lcnt_ff == 5'd31) ? ST_LNLO : ST_LMUL;
         end
         ST_LNLO: state_in = ST_LNHI;
         ST_LNHI: begin
            acc_in   = 108'(prod_ff);
            state_in = ST_LNADD;
         end
         ST_LNADD: state_in = ST_TWAIT;
         ST_TWAIT: begin
            if (div_done) begin
               time_in  = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
               state_in = ST_TGLO;
            end
         end
         ST_TGLO: state_in = ST_TGHI;
         ST_TGHI: begin
            acc_in   = 108'(prod_ff);
            state_in = ST_TGADD;
         end
         ST_TGADD: begin
            target_in = wsum[TGT_W-1:0];
            cum_in    = '0;
            idx_in    = '0;
            found_in  = 1'b0;
            pick_in   = RXN_DIE_G;
            state_in  = ST_SEL;
         end
         ST_SEL: begin
            cum_in = cum_next;
            if (!found_ff && (target_ff < {cum_next, 32'b0})) begin
               pick_in  = idx_ff;
               found_in = 1'b1;
            end
            if (idx_ff == RXN_DIE_G) state_in = ST_UPD;
            else idx_in = idx_ff + 1'b1;
         end
         ST_UPD: begin
            s_in = bump(s_ff, eff.s);
            n_in = bump(n_ff, eff.n);
            g_in = bump(g_ff, eff.g);
            state_in = ST_MARK;
         end
         ST_MARK: begin
            if (!app_ff && g_ff != '0) begin
               app_in   = 1'b1;
               app_t_in = time_ff;
               if (cfg_stop_ff == STOP_APPEAR) stop = 1'b1;
            end
            if (!est_ff && g20 > MW'(base)) begin
               est_in   = 1'b1;
               est_t_in = time_ff;
               if (cfg_stop_ff == STOP_ESTABLISH) stop = 1'b1;
            end else if (!fix_ff && g20 > b19) begin
               fix_in   = 1'b1;
               fix_t_in = time_ff;
               if (cfg_stop_ff != STOP_NEVER) stop = 1'b1;
            end
            if (stop || time_ff >= cfg_tend_ff) begin
               run_in  = 1'b0;
               stat_in = STAT_END;
            end else begin
               stat_in = STAT_OK;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = DATA_W'({fix_t_ff, est_t_ff, app_t_ff, g_ff, n_ff, s_ff,
                                       time_ff});
               rsp_user_in  = {fix_ff, est_ff, app_ff, stat_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_gn_ff     <= '0;
         cfg_gg_ff     <= '0;
         cfg_ds_ff     <= '0;
         cfg_dn_ff     <= '0;
         cfg_init_n_ff <= '0;
         cfg_tend_ff   <= '0;
         cfg_stop_ff   <= '0;
         cfg_fbase_ff  <= 1'b0;
         state_ff      <= ST_IDLE;
         run_ff        <= 1'b0;
         s_ff          <= '0;
         n_ff          <= '0;
         g_ff          <= '0;
         time_ff       <= '0;
         start_tot_ff  <= '0;
         app_t_ff      <= '0;
         est_t_ff      <= '0;
         fix_t_ff      <= '0;
         app_ff        <= 1'b0;
         est_ff        <= 1'b0;
         fix_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_gn_ff     <= cfg_gn_in;
         cfg_gg_ff     <= cfg_gg_in;
         cfg_ds_ff     <= cfg_ds_in;
         cfg_dn_ff     <= cfg_dn_in;
         cfg_init_n_ff <= cfg_init_n_in;
         cfg_tend_ff   <= cfg_tend_in;
         cfg_stop_ff   <= cfg_stop_in;
         cfg_fbase_ff  <= cfg_fbase_in;
         state_ff      <= state_in;
         run_ff        <= run_in;
         s_ff          <= s_in;
         n_ff          <= n_in;
         g_ff          <= g_in;
         time_ff       <= time_in;
         start_tot_ff  <= start_tot_in;
         app_t_ff      <= app_t_in;
         est_t_ff      <= est_t_in;
         fix_t_ff      <= fix_t_in;
         app_ff        <= app_in;
         est_ff        <= est_in;
         fix_ff        <= fix_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff     <= stat_in;
      r1_ff       <= r1_in;
      r2_ff       <= r2_in;
      off_ff      <= off_in;
      hill_ff     <= hill_in;
      idx_ff      <= idx_in;
      a0_ff       <= a0_in;
      prop_ff     <= prop_in;
      m_ff        <= m_in;
      e_ff        <= e_in;
      frac_ff     <= frac_in;
      lcnt_ff     <= lcnt_in;
      acc_ff      <= acc_in;
      target_ff   <= target_in;
      cum_ff      <= cum_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `GSSA_ASSERT_IMP(a_fix_needs_est, fix_ff, est_ff, "fixation marked before establishment")
   `GSSA_ASSERT_IMP(a_est_needs_app, est_ff, app_ff, "establishment marked before appearance")
   `GSSA_ASSERT_NXT(a_busy_after_take, req_tvalid && req_tready, !req_tready,
                    "request taken but engine still idle")

endmodule
